// File: src/cole_pkg.sv
package cole_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READOUT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_READOUT
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DEL_RD,
      BK_DEL_CMP,
      BK_SHF_RD,
      BK_SHF_WR,
      BK_OUT_RD,
      BK_OUT_SEND,
      BK_SEND
   } back_state_type;

endpackage

// File: src/cole_if.sv
interface cole_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [cole_pkg::MODE_W-1:0]              mode;
   logic signed [cole_pkg::VALUE_W-1:0]      value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cole_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [cole_pkg::STATUS_W-1:0]            status;
   logic signed [cole_pkg::VALUE_W-1:0]      entry_value;
   logic                                     backward;
   logic                                     last;

   modport source (output valid, output status, output entry_value, output backward,
                   output last, input ready);
   modport sink   (input valid, input status, input entry_value, input backward,
                   input last, output ready);
endinterface

// File: src/cole_front.sv
module cole_front (
   cole_req_if.sink                req_if,
   output cole_pkg::cmd_chan_type  push,
   input  logic                    push_ready
);
   import cole_pkg::*;

   logic accept;

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && push_ready;

   always_comb begin
      push.valid     = 1'b0;
      push.cmd.op    = OP_INSERT;
      push.cmd.value = req_if.value;
      case (req_if.mode)
         MODE_INSERT: begin
            push.valid  = accept;
            push.cmd.op = OP_INSERT;
         end
         MODE_DELETE: begin
            push.valid  = accept;
            push.cmd.op = OP_DELETE;
         end
         MODE_READOUT: begin
            push.valid  = accept;
            push.cmd.op = OP_READOUT;
         end
         default: begin
            // unused mode is taken and dropped
            push.valid = 1'b0;
         end
      endcase
   end
endmodule

// File: src/cole_queue.sv
module cole_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  cole_pkg::cmd_chan_type  push,
   output logic                    push_ready,
   output cole_pkg::cmd_chan_type  pop,
   input  logic                    pop_ready
);
   import cole_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop.valid  = (fill_ff != 2'd0);
   assign pop.cmd    = slot_ff[rd_ptr_ff];

   assign do_push = push.valid && push_ready;
   assign do_pop  = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + (do_push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end
endmodule

// File: src/cole_back.sv
module cole_back (
   input  logic                    clock,
   input  logic                    reset,
   input  cole_pkg::cmd_chan_type  pop,
   output logic                    pop_ready,
   cole_rsp_if.source              rsp_if
);
   import cole_pkg::*;

   logic signed [VALUE_W-1:0]  entry_store_ff [CAPACITY];
   logic signed [VALUE_W-1:0]  rd_data_ff;

   back_state_type             state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic                       backward_ff, backward_in;
   logic [STATUS_W-1:0]        status_ff, status_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_backward_ff, rsp_backward_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic signed [VALUE_W-1:0]  wr_data;
   logic [IDX_W-1:0]           rd_addr;
   logic [IDX_W-1:0]           idx_plus1;
   logic                       at_tail;
   logic                       is_full;
   logic                       is_empty;
   logic                       out_free;

   assign idx_plus1 = idx_ff + IDX_W'(1);
   assign at_tail   = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.entry_value = rsp_value_ff;
   assign rsp_if.backward    = rsp_backward_ff;
   assign rsp_if.last        = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop.valid) begin
               case (pop.cmd.op)
                  OP_INSERT:  state_in = BK_SEND;
                  OP_DELETE:  state_in = is_empty ? BK_SEND : BK_DEL_RD;
                  OP_READOUT: state_in = is_empty ? BK_SEND : BK_OUT_RD;
                  default:    state_in = BK_IDLE;
               endcase
            end
         end
         BK_DEL_RD:  state_in = BK_DEL_CMP;
         BK_DEL_CMP: begin
            if (rd_data_ff == value_ff) begin
               state_in = BK_SHF_RD;
            end else if (at_tail) begin
               state_in = BK_SEND;
            end else begin
               state_in = BK_DEL_RD;
            end
         end
         BK_SHF_RD:  state_in = at_tail ? BK_SEND : BK_SHF_WR;
         BK_SHF_WR:  state_in = BK_SHF_RD;
         BK_OUT_RD:  state_in = BK_OUT_SEND;
         BK_OUT_SEND: begin
            if (out_free) begin
               state_in = (backward_ff && idx_ff == '0) ? BK_IDLE : BK_OUT_RD;
            end
         end
         BK_SEND: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready       = 1'b0;
      wr_en           = 1'b0;
      wr_addr         = idx_ff;
      wr_data         = rd_data_ff;
      rd_addr         = idx_ff;
      idx_in          = idx_ff;
      count_in        = count_ff;
      value_in        = value_ff;
      backward_in     = backward_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_backward_in = rsp_backward_ff;
      rsp_last_in     = rsp_last_ff;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop.valid) begin
               value_in    = pop.cmd.value;
               idx_in      = '0;
               backward_in = 1'b0;
               status_in   = ST_OK;
               case (pop.cmd.op)
                  OP_INSERT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = pop.cmd.value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_DELETE, OP_READOUT: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         BK_DEL_CMP: begin
            if (rd_data_ff != value_ff) begin
               if (at_tail) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  idx_in = idx_plus1;
               end
            end
         end
         BK_SHF_RD: begin
            rd_addr = idx_plus1;
            if (at_tail) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = ST_OK;
            end
         end
         BK_SHF_WR: begin
            rd_addr = idx_plus1;
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            idx_in  = idx_plus1;
         end
         BK_OUT_SEND: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_OK;
               rsp_value_in    = rd_data_ff;
               rsp_backward_in = backward_ff;
               rsp_last_in     = backward_ff && (idx_ff == '0);
               if (!backward_ff) begin
                  if (at_tail) begin
                     backward_in = 1'b1;
                  end else begin
                     idx_in = idx_plus1;
                  end
               end else if (idx_ff != '0) begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         BK_SEND: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_value_in    = '0;
               rsp_backward_in = 1'b0;
               rsp_last_in     = 1'b1;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      value_ff        <= value_in;
      backward_ff     <= backward_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_backward_ff <= rsp_backward_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_addr];
   end
endmodule

// File: src/circular_ordered_list_engine.sv
// channel   | dir | handshake           | payload
// req_if    | in  | valid/ready         | mode, value
// rsp_if    | out | valid/ready         | status, entry_value, backward, last
//
// Insert: result via BK_SEND. Delete: BK_DEL_RD, BK_DEL_CMP per entry scanned
// plus BK_SHF_RD, BK_SHF_WR per entry moved up; store reads are registered.
// Readout: BK_OUT_RD, BK_OUT_SEND per result. Reset clears state, entry count
// and result valid, not the store. A two-deep request queue lets requests in
// while the back end works or the result register waits on rsp_if.ready.
module circular_ordered_list_engine (
   input logic        clock,
   input logic        reset,
   cole_req_if.sink   req_if,
   cole_rsp_if.source rsp_if
);
   import cole_pkg::*;

   cmd_chan_type push;
   logic         push_ready;
   cmd_chan_type pop;
   logic         pop_ready;

   cole_front u_front (
      .req_if     (req_if),
      .push       (push),
      .push_ready (push_ready)
   );

   cole_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   cole_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

`ifndef ASSERT_OFF
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready)
      else $error("queue push while full");

   a_mid_is_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.last |-> rsp_if.status == ST_OK)
      else $error("non-final response is not an entry");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status != ST_OK |->
         rsp_if.entry_value == 0 && !rsp_if.backward && rsp_if.last)
      else $error("status response carries entry fields");
`endif
endmodule
